>>> hw/rtl/cbd_pkg.sv
// Shared types and constants of the chunked body decoder.
package cbd_pkg;

    // Parser phase of the front end.
    typedef enum logic [2:0] {
        PH_LINE = 3'd0,
        PH_DATA = 3'd1,
        PH_SKIP = 3'd2,
        PH_DONE = 3'd3
    } t_phase;

    // Progress through a size line.
    typedef enum logic [1:0] {
        ST_WS     = 2'd0,
        ST_DIGITS = 2'd1,
        ST_IGNORE = 2'd2
    } t_stage;

    // One decoded result word as it travels through the queue.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       body_end;
    } t_result;

    localparam int unsigned TRAIL_SKIP = 2;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QAW        = $clog2(QDEPTH);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

>>> hw/rtl/cbd_front.sv
// Front end: accepts raw body words, parses size lines and tracks chunk progress.
module cbd_front #(
    parameter int SIZE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_body_byte,
    input  logic            i_body_start,
    input  logic            i_space,
    output logic            o_ready,
    output logic            o_push,
    output cbd_pkg::t_result o_entry
);
    import cbd_pkg::*;

    t_phase               r_phase, n_phase, eff_phase;
    t_stage               r_stage, n_stage, eff_stage;
    logic [SIZE_BITS-1:0] r_accum, n_accum, eff_accum;
    logic [SIZE_BITS-1:0] r_left, n_left, left_dec;
    logic                 accept;
    logic                 hex_ok;
    logic [3:0]           hex_dig;
    logic                 blank;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    // Hex digit decode of the incoming word.
    always_comb begin
        hex_ok  = 1'b1;
        hex_dig = 4'd0;
        if (i_body_byte >= 8'h30 && i_body_byte <= 8'h39) begin
            hex_dig = 4'(i_body_byte - 8'h30);
        end else if (i_body_byte >= 8'h61 && i_body_byte <= 8'h66) begin
            hex_dig = 4'(i_body_byte - 8'h57);
        end else if (i_body_byte >= 8'h41 && i_body_byte <= 8'h46) begin
            hex_dig = 4'(i_body_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign blank = (i_body_byte == CH_SPACE) || (i_body_byte == CH_TAB) ||
                   (i_body_byte == CH_CR) || (i_body_byte == CH_VT) ||
                   (i_body_byte == CH_FF);

    // A start flag puts the parser at a fresh size line before this word is seen.
    assign eff_phase = i_body_start ? PH_LINE : r_phase;
    assign eff_stage = i_body_start ? ST_WS : r_stage;
    assign eff_accum = i_body_start ? '0 : r_accum;
    assign left_dec  = (r_left != '0) ? r_left - SIZE_BITS'(1) : '0;

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_stage = r_stage;
        n_accum = r_accum;
        n_left  = r_left;
        if (accept) begin
            n_phase = eff_phase;
            n_stage = eff_stage;
            n_accum = eff_accum;
            unique case (eff_phase)
                PH_LINE: begin
                    if (i_body_byte == CH_LF) begin
                        // Only a line with digits can hold a non-zero size.
                        if (eff_accum != '0) begin
                            n_left  = eff_accum;
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else if (eff_stage != ST_IGNORE) begin
                        if (hex_ok) begin
                            // Shifting in a digit overflows only if the top nibble is set.
                            if (eff_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                                n_accum = '1;
                            end else begin
                                n_accum = {eff_accum[SIZE_BITS-5:0], hex_dig};
                            end
                            n_stage = ST_DIGITS;
                        end else if (!(eff_stage == ST_WS && blank)) begin
                            n_stage = ST_IGNORE;
                        end
                    end
                end
                PH_DATA: begin
                    n_left = r_left - SIZE_BITS'(1);
                    if (r_left == SIZE_BITS'(1)) begin
                        n_phase = PH_SKIP;
                        n_left  = SIZE_BITS'(TRAIL_SKIP);
                    end
                end
                PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_LINE;
                        n_stage = ST_WS;
                        n_accum = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result generation.
    always_comb begin
        o_push               = 1'b0;
        o_entry.payload_byte = 8'd0;
        o_entry.body_end     = 1'b0;
        unique case (eff_phase)
            PH_LINE: begin
                if (i_body_byte == CH_LF && eff_accum == '0) begin
                    o_push           = accept;
                    o_entry.body_end = 1'b1;
                end
            end
            PH_DATA: begin
                o_push               = accept;
                o_entry.payload_byte = i_body_byte;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_stage <= ST_WS;
            r_accum <= '0;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_stage <= n_stage;
            r_accum <= n_accum;
            r_left  <= n_left;
        end
    end

endmodule

>>> hw/rtl/cbd_queue.sv
// Short result queue between the front end and the output stage.
module cbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cbd_pkg::t_result i_entry,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_valid,
    output cbd_pkg::t_result o_entry
);
    import cbd_pkg::*;

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_count, n_count;
    logic             do_pop;

    assign o_space = (r_count != (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/cbd_back.sv
// Output stage: holds one result word for the receiver and refills from the queue.
module cbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  cbd_pkg::t_result i_q_entry,
    output logic             o_q_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_payload_byte,
    output logic             o_body_end
);
    import cbd_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_q_pop        = i_q_valid && (!r_valid || i_ready);
    assign o_valid        = r_valid;
    assign o_payload_byte = r_data.payload_byte;
    assign o_body_end     = r_data.body_end;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

>>> hw/rtl/chunked_body_decoder.sv
// Top level of the chunked body decoder.
//
// The input channel carries one raw word of a chunked message body per handshake
// (i_valid / o_ready), with i_body_start flagging the first word of a new body.
// The output channel (o_valid / i_ready) carries payload words, and a single
// end word with o_body_end set once a zero-size or digitless size line is seen.
// The front end parses size lines and counts chunk bytes, accepting one word
// per cycle while the queue has room; a four-entry queue separates it from
// the output register, so the front keeps taking words while a result waits
// for the receiver. Throughput is one word per cycle whenever the receiver
// takes results as they come. The edge that accepts a word writes its result
// into the queue, and a later edge loads it into the free output register.
// When the receiver stalls, the queue fills and o_ready drops once all four
// entries are held; words that produce no result (size lines, trailing CR LF,
// words after the end) also wait while the queue is full.
// Reset clears the parser to the start of a size line and empties the queue and
// the output register. SIZE_BITS sets the width of the chunk size accumulator;
// sizes that overflow it saturate at the all-ones value.
module chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_body_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_body_end
);
    import cbd_pkg::*;

    logic    push;
    logic    space;
    logic    q_valid;
    logic    q_pop;
    t_result push_entry;
    t_result q_entry;

    cbd_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_body_byte (i_body_byte),
        .i_body_start(i_body_start),
        .i_space     (space),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    cbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_space (space),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    cbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_payload_byte(o_payload_byte),
        .o_body_end    (o_body_end)
    );

endmodule

>>> test/cbd_checker.sv
// Checker for the chunked body decoder: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module cbd_checker #(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_body_start,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_payload_byte,
    input  logic       i_body_end,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_payloads,
    output int         o_ends
);

    import cbd_pkg::*;

    localparam logic [SIZE_BITS-1:0] ACC_FULL = {SIZE_BITS{1'b1}};

    // Shadow copy of the parser state.
    t_phase               phase_r;
    t_stage               stage_r;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] left_cnt;

    t_result due_results[$];
    int      mism_cnt    = 0;
    int      payload_cnt = 0;
    int      end_cnt     = 0;

    assign o_mismatches = mism_cnt;
    assign o_payloads   = payload_cnt;
    assign o_ends       = end_cnt;

    task automatic flag_mismatch(input string msg);
        mism_cnt++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    task automatic open_size_line();
        phase_r  = PH_LINE;
        stage_r  = ST_WS;
        size_acc = '0;
    endtask

    // Advances the shadow parser by one input word and gives the result it causes, if any.
    task automatic decode_word(input logic [7:0] c, input logic start,
                               output bit has, output t_result res);
        int                   d;
        logic [SIZE_BITS-1:0] room;
        has = 1'b0;
        res = '0;
        if (start)
            open_size_line();
        case (phase_r)
            PH_LINE: begin
                if (c == CH_LF) begin
                    if ((stage_r == ST_DIGITS || stage_r == ST_IGNORE) && size_acc != '0) begin
                        left_cnt = size_acc;
                        phase_r  = PH_DATA;
                    end else begin
                        // Zero size or no digits at all: the body ends here.
                        phase_r      = PH_DONE;
                        has          = 1'b1;
                        res.body_end = 1'b1;
                    end
                end else if (stage_r != ST_IGNORE) begin
                    d = nibble_of(c);
                    if (d >= 0) begin
                        room = (ACC_FULL - SIZE_BITS'(d)) >> 4;
                        if (size_acc > room)
                            size_acc = ACC_FULL;
                        else
                            size_acc = (size_acc << 4) + SIZE_BITS'(d);
                        stage_r = ST_DIGITS;
                    end else if (!(stage_r == ST_WS && is_blank(c))) begin
                        stage_r = ST_IGNORE;
                    end
                end
            end
            PH_DATA: begin
                has              = 1'b1;
                res.payload_byte = c;
                left_cnt         = left_cnt - SIZE_BITS'(1);
                if (left_cnt == '0) begin
                    phase_r  = PH_SKIP;
                    left_cnt = SIZE_BITS'(TRAIL_SKIP);
                end
            end
            PH_SKIP: begin
                if (left_cnt != '0)
                    left_cnt = left_cnt - SIZE_BITS'(1);
                if (left_cnt == '0)
                    open_size_line();
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : track
        bit      has;
        t_result want;
        if (!i_rst_n) begin
            open_size_line();
            left_cnt = '0;
            due_results.delete();
        end else begin
            // New words are taken in before results are retired at the same edge.
            if (i_in_valid && i_in_ready) begin
                decode_word(i_body_byte, i_body_start, has, want);
                if (has)
                    due_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word: payload %02h end %0b",
                                            i_payload_byte, i_body_end));
                end else begin
                    want = due_results.pop_front();
                    if (i_payload_byte !== want.payload_byte)
                        flag_mismatch($sformatf("payload_byte %02h, predicted %02h",
                                                i_payload_byte, want.payload_byte));
                    if (i_body_end !== want.body_end)
                        flag_mismatch($sformatf("body_end %0b, predicted %0b",
                                                i_body_end, want.body_end));
                    if (want.body_end)
                        end_cnt++;
                    else
                        payload_cnt++;
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

>>> test/tb_chunked_body_decoder.sv
// Top of the chunked body decoder testbench: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_chunked_body_decoder;

    import cbd_pkg::*;

    localparam int TARGET_WORDS = 1700;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_LEN     = 300;
    localparam int IDLE_PCT     = 24;

    // One raw word as queued for the sender.
    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_body_byte;
    logic       i_body_start;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_payload_byte;
    logic       o_body_end;

    int mism_count;
    int due_count;
    int payload_count;
    int end_count;

    t_word raw_words[$];
    bit    start_next = 1'b0;
    int    words_sent = 0;
    // While set, neither side idles at random; receiver hold-offs still run.
    logic  steady;

    always #5 i_clk = ~i_clk;

    chunked_body_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_body_byte    (i_body_byte),
        .i_body_start   (i_body_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_payload_byte (o_payload_byte),
        .o_body_end     (o_body_end)
    );

    cbd_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_body_byte    (i_body_byte),
        .i_body_start   (i_body_start),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_payload_byte (o_payload_byte),
        .i_body_end     (o_body_end),
        .o_mismatches   (mism_count),
        .o_pending      (due_count),
        .o_payloads     (payload_count),
        .o_ends         (end_count)
    );

    // Queues one word; the start flag goes on the first word queued after start_next is set.
    task automatic add(input logic [7:0] b);
        raw_words.push_back('{value: b, first: start_next});
        start_next = 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CH_LF) ? 8'("x") : b;
    endfunction

    // A size line as a real peer might write it: optional blanks, optional leading
    // zeros, mixed-case digits, an optional extension and CR LF or a bare LF.
    task automatic add_size_line(input logic [31:0] size);
        logic [7:0] blanks[5];
        bit         started;
        logic [3:0] nib;
        blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
        started = 1'b0;
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
            add(blanks[$urandom_range(4)]);
        repeat ($urandom_range(4) == 0 ? $urandom_range(1, 2) : 0)
            add("0");
        for (int k = 7; k >= 0; k--) begin
            nib = size[4*k +: 4];
            if (nib != 4'd0 || started || k == 0) begin
                add(hex_char(nib, 1'($urandom_range(1))));
                started = 1'b1;
            end
        end
        if ($urandom_range(3) == 0) begin
            add(";");
            repeat ($urandom_range(1, 6))
                add(any_but_lf());
        end
        if ($urandom_range(4) != 0)
            add(CH_CR);
        add(CH_LF);
    endtask

    // A whole body: a few chunks, the zero line and perhaps some words after the end.
    task automatic add_body();
        logic [31:0] size;
        start_next = 1'b1;
        repeat ($urandom_range(1, 4)) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            add_size_line(size);
            repeat (size)
                add(8'($urandom_range(255)));
            if ($urandom_range(4) != 0) begin
                add(CH_CR);
                add(CH_LF);
            end else begin
                add(8'($urandom_range(255)));
                add(8'($urandom_range(255)));
            end
        end
        add_size_line('0);
        repeat ($urandom_range(0, 2))
            add(8'($urandom_range(255)));
    endtask

    // Sends one word, idling at random before offering it, and returns at the
    // edge that accepts it.
    task automatic send_word(input t_word w);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_body_byte  <= w.value;
        i_body_start <= w.first;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        words_sent++;
        steady <= (words_sent >= 900 && words_sent < 1150);
    endtask

    task automatic send_queued();
        while (raw_words.size() > 0)
            send_word(raw_words.pop_front());
    endtask

    // Receiver: random idling, one long hold-off early on so that the queue fills
    // and the input stalls, and now and then a shorter one.
    initial begin : receiver
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc       = 0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == HOLD_AT)
                hold_left = HOLD_LEN;
            else if (hold_left == 0 && !steady && $urandom_range(2999) == 0)
                hold_left = $urandom_range(40, 120);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // Ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int  kind;
        int  cut;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_body_byte  <= 8'h00;
        i_body_start <= 1'b0;
        steady       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Every blank is skipped before a one-byte chunk whose size
        // line carries junk after the digit; then a 0x prefix, which reads as a
        // zero size; a word after the end that must vanish; a signed, digitless
        // line; and a chunk abandoned part way by a start flag on a zero line.
        start_next = 1'b1;
        add(CH_SPACE); add(CH_TAB); add(CH_VT); add(CH_FF); add(CH_CR);
        add("1"); add("z"); add(CH_LF);
        add(8'hFF);
        add(8'h00); add(8'hAA);
        add("0"); add("x"); add("5"); add(CH_LF);
        add(8'h41);
        start_next = 1'b1;
        add("-"); add("+"); add("3"); add(CH_LF);
        start_next = 1'b1;
        add("A"); add("b"); add(CH_LF);
        add(8'h80); add(8'h7F);
        start_next = 1'b1;
        add("0"); add(CH_LF);
        send_queued();

        // Random part: mostly well-formed bodies, with cut-short bodies, sizes that
        // saturate the accumulator and loose noise mixed in.
        while (words_sent < TARGET_WORDS) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                add_body();
            end else if (kind < 75) begin
                add_body();
                cut = $urandom_range(1, raw_words.size());
                while (raw_words.size() > cut)
                    void'(raw_words.pop_back());
                if ($urandom_range(1))
                    raw_words[$urandom_range(cut - 1)].value = 8'($urandom_range(255));
            end else if (kind < 85) begin
                start_next = 1'b1;
                repeat ($urandom_range(9, 12))
                    add(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
                add(CH_LF);
                repeat ($urandom_range(1, 20))
                    add(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    start_next = ($urandom_range(7) == 0);
                    add(8'($urandom_range(255)));
                end
            end
            send_queued();
        end
        i_valid <= 1'b0;

        // Let the last word reach the checker, drain what is still due, then idle a little.
        @(posedge i_clk);
        while (due_count != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d body words; checked %0d payload words and %0d end markers.",
                 words_sent, payload_count, end_count);
        $display("Bodies were whole, cut short, oversized or noise; the receiver held off %0d %s",
                 HOLD_LEN, "cycles once with the input stalled.");
        if (mism_count == 0 && due_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
